>>> rtl/core/igt_pkg.sv
`default_nettype none

package igt_pkg;

  // Table and coordinate sizing.
  localparam int TRACK_SLOTS = 32;
  localparam int COORD_BITS  = 12;
  localparam int SLOT_BITS   = $clog2(TRACK_SLOTS);
  localparam int COUNT_BITS  = $clog2(TRACK_SLOTS + 1);

  // Fixed field widths of the ports.
  localparam int FIELD_COORD_BITS = 12;
  localparam int ID_BITS          = 16;
  localparam int FRAME_BITS       = 32;
  localparam int STEP_BITS        = 14;
  localparam int SLOT_OUT_BITS    = 5;

  // Arithmetic widths derived from the coordinate and step widths.
  localparam int AREA_BITS  = 2 * COORD_BITS;
  localparam int UNION_BITS = AREA_BITS + 1;
  localparam int PROD_BITS  = AREA_BITS + UNION_BITS;
  localparam int SCORE_BITS = AREA_BITS + 3;
  localparam int LIMIT_BITS = STEP_BITS + 3;

  // Tracks idle beyond this many steps are not matched.
  localparam int IDLE_STEPS = 5;
  // Match threshold is 1/MATCH_DEN of the union.
  localparam int MATCH_DEN  = 5;

  // Configuration port.
  localparam int PADDR_BITS = 3;
  localparam int REG_BITS   = PADDR_BITS - 2;
  localparam logic [REG_BITS-1:0]  REG_STEP_FRAMES = '0;
  localparam logic [STEP_BITS-1:0] STEP_RESET      = STEP_BITS'(6);

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } igt_box_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } igt_state_t;

  // Write into the track table.
  typedef struct packed {
    logic                  en;
    logic                  ident_en;
    logic [SLOT_BITS-1:0]  addr;
    logic [ID_BITS-1:0]    ident;
    igt_box_t              box;
    logic [FRAME_BITS-1:0] frame;
  } igt_wr_t;

  // Registered read from the track table.
  typedef struct packed {
    logic                  valid;
    logic [SLOT_BITS-1:0]  slot;
    logic [ID_BITS-1:0]    ident;
    igt_box_t              box;
    logic [FRAME_BITS-1:0] frame;
  } igt_rd_t;

  // Context of the detection being associated.
  typedef struct packed {
    logic                  clear;
    igt_box_t              det;
    logic [FRAME_BITS-1:0] frame;
    logic [LIMIT_BITS-1:0] limit;
    logic [AREA_BITS-1:0]  det_area;
  } igt_job_t;

  // Best candidate found so far.
  typedef struct packed {
    logic                  found;
    logic [SLOT_BITS-1:0]  slot;
    logic [ID_BITS-1:0]    ident;
    logic [AREA_BITS-1:0]  inter;
    logic [UNION_BITS-1:0] uni;
  } igt_best_t;

endpackage

`default_nettype wire

>>> rtl/core/igt_track_mem.sv
`default_nettype none

module igt_track_mem
  import igt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 rd_en,
  input  wire logic [SLOT_BITS-1:0] rd_addr,
  input  wire igt_wr_t              wr,
  output igt_rd_t                   rd
);

  logic [ID_BITS-1:0]    ident_mem [TRACK_SLOTS];
  igt_box_t              box_mem   [TRACK_SLOTS];
  logic [FRAME_BITS-1:0] frame_mem [TRACK_SLOTS];

  logic                  rd_valid;
  logic [SLOT_BITS-1:0]  rd_slot;
  logic [ID_BITS-1:0]    rd_ident;
  igt_box_t              rd_box;
  logic [FRAME_BITS-1:0] rd_frame;

  // Write port: the identity is only written when a track is created.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      box_mem[wr.addr]   <= wr.box;
      frame_mem[wr.addr] <= wr.frame;
      if (wr.ident_en) begin
        ident_mem[wr.addr] <= wr.ident;
      end
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_slot  <= rd_addr;
    rd_ident <= ident_mem[rd_addr];
    rd_box   <= box_mem[rd_addr];
    rd_frame <= frame_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

  assign rd = '{valid: rd_valid, slot: rd_slot, ident: rd_ident, box: rd_box,
                frame: rd_frame};

endmodule

`default_nettype wire

>>> rtl/core/igt_iou_unit.sv
`default_nettype none

module igt_iou_unit
  import igt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire igt_rd_t  rd,
  input  wire igt_job_t job,
  output igt_best_t     best,
  output logic          idle
);

  // Overlap of two intervals [p, p+pl) and [q, q+ql), zero when disjoint.
  function automatic logic [COORD_BITS-1:0] overlap(
    input logic [COORD_BITS-1:0] p,
    input logic [COORD_BITS-1:0] pl,
    input logic [COORD_BITS-1:0] q,
    input logic [COORD_BITS-1:0] ql
  );
    logic [COORD_BITS-1:0] lo;
    logic [COORD_BITS:0]   e1;
    logic [COORD_BITS:0]   e2;
    logic [COORD_BITS:0]   hi;
    lo = (p > q) ? p : q;
    e1 = {1'b0, p} + {1'b0, pl};
    e2 = {1'b0, q} + {1'b0, ql};
    hi = (e1 < e2) ? e1 : e2;
    overlap = (hi > {1'b0, lo}) ? COORD_BITS'(hi - {1'b0, lo}) : '0;
  endfunction

  // Stage B: overlaps and age test.
  logic                     b_valid;
  logic                     b_live;
  logic [SLOT_BITS-1:0]     b_slot;
  logic [ID_BITS-1:0]       b_ident;
  logic [COORD_BITS-1:0]    b_ox;
  logic [COORD_BITS-1:0]    b_oy;
  logic [COORD_BITS-1:0]    b_tw;
  logic [COORD_BITS-1:0]    b_th;
  logic signed [FRAME_BITS:0] age;
  logic                     stale;

  // Stage C: intersection and track area.
  logic                     c_valid;
  logic                     c_live;
  logic [SLOT_BITS-1:0]     c_slot;
  logic [ID_BITS-1:0]       c_ident;
  logic [AREA_BITS-1:0]     c_inter;
  logic [AREA_BITS-1:0]     c_tarea;
  logic [UNION_BITS-1:0]    uni_sum;

  // Stage D: union and candidate qualification.
  logic                     d_valid;
  logic                     d_ok;
  logic [SLOT_BITS-1:0]     d_slot;
  logic [ID_BITS-1:0]       d_ident;
  logic [AREA_BITS-1:0]     d_inter;
  logic [UNION_BITS-1:0]    d_uni;

  // Stage E: exact fraction compare against the running best.
  logic                     best_found;
  logic [SLOT_BITS-1:0]     best_slot;
  logic [ID_BITS-1:0]       best_ident;
  logic [AREA_BITS-1:0]     best_inter;
  logic [UNION_BITS-1:0]    best_uni;
  logic [PROD_BITS-1:0]     cross_new;
  logic [PROD_BITS-1:0]     cross_best;
  logic                     better;

  // A track last seen in a later frame gives a negative age and stays live.
  assign age   = $signed({1'b0, job.frame}) - $signed({1'b0, rd.frame});
  assign stale = age > $signed({{(FRAME_BITS - LIMIT_BITS + 1){1'b0}}, job.limit});

  always_ff @(posedge clk) begin
    b_live  <= !stale;
    b_slot  <= rd.slot;
    b_ident <= rd.ident;
    b_ox    <= overlap(rd.box.x, rd.box.w, job.det.x, job.det.w);
    b_oy    <= overlap(rd.box.y, rd.box.h, job.det.y, job.det.h);
    b_tw    <= rd.box.w;
    b_th    <= rd.box.h;
  end

  always_ff @(posedge clk) begin
    c_live  <= b_live;
    c_slot  <= b_slot;
    c_ident <= b_ident;
    c_inter <= b_ox * b_oy;
    c_tarea <= b_tw * b_th;
  end

  assign uni_sum = UNION_BITS'(c_tarea) + UNION_BITS'(job.det_area) - UNION_BITS'(c_inter);

  always_ff @(posedge clk) begin
    d_ok    <= c_live && (c_inter != '0) && (uni_sum != '0);
    d_slot  <= c_slot;
    d_ident <= c_ident;
    d_inter <= c_inter;
    d_uni   <= uni_sum;
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      b_valid <= rd.valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  // inter/uni beats the best when inter * best_uni > best_inter * uni.
  assign cross_new  = d_inter * best_uni;
  assign cross_best = best_inter * d_uni;
  assign better     = cross_new > cross_best;

  // Strictly greater only, so the lowest slot keeps a tie.
  always_ff @(posedge clk) begin
    if (rst || job.clear) begin
      best_found <= 1'b0;
      best_inter <= '0;
      best_uni   <= UNION_BITS'(1);
      best_slot  <= '0;
      best_ident <= '0;
    end else if (d_valid && d_ok && better) begin
      best_found <= 1'b1;
      best_inter <= d_inter;
      best_uni   <= d_uni;
      best_slot  <= d_slot;
      best_ident <= d_ident;
    end
  end

  assign best = '{found: best_found, slot: best_slot, ident: best_ident,
                  inter: best_inter, uni: best_uni};
  assign idle = !(rd.valid || b_valid || c_valid || d_valid);

endmodule

`default_nettype wire

>>> rtl/core/iou_greedy_track_association.sv
// Greedy IoU track association. A request (frame index and detection box) is
// taken when start is high while busy is low. The block scores every filled
// track slot against the box, one slot per clock through a single IoU compare
// unit, then updates the best track, appends a new one, or, with no match
// and a full table, drops the request. The shared compare unit's slot scan
// is followed by a pipeline drain and a decision, and busy is high through
// all of them. The result appears for one cycle with done high and cannot be
// held off, so it must be captured then. Tracks idle more than five times
// step_frames frames (five if step_frames is zero) are not matched.
`default_nettype none

module iou_greedy_track_association
  import igt_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Configuration port.
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [PADDR_BITS-1:0]       paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  // Request.
  input  wire logic                        start,
  input  wire logic [FRAME_BITS-1:0]       frame_index,
  input  wire logic [FIELD_COORD_BITS-1:0] box_x,
  input  wire logic [FIELD_COORD_BITS-1:0] box_y,
  input  wire logic [FIELD_COORD_BITS-1:0] box_w,
  input  wire logic [FIELD_COORD_BITS-1:0] box_h,
  output logic                             busy,
  // Result.
  output logic                             done,
  output logic      [ID_BITS-1:0]          track_id,
  output logic      [SLOT_OUT_BITS-1:0]    slot_index,
  output logic                             created,
  output logic                             table_full
);

  logic [STEP_BITS-1:0]  step_frames;
  igt_state_t            state;
  igt_state_t            state_next;
  logic [SLOT_BITS-1:0]  scan_idx;
  logic [COUNT_BITS-1:0] track_count;
  logic [COUNT_BITS-1:0] track_count_next;
  logic [ID_BITS-1:0]    next_identity;
  logic [ID_BITS-1:0]    next_identity_next;

  logic                  accept;
  logic                  cfg_write;
  logic                  rd_en;
  igt_wr_t               wr;
  igt_rd_t               rd;
  igt_job_t              job;
  igt_best_t             best;
  logic                  unit_idle;

  igt_box_t              det_in;
  logic [STEP_BITS-1:0]  step_eff;
  logic [AREA_BITS-1:0]  det_area_in;
  igt_box_t              job_det;
  logic [FRAME_BITS-1:0] job_frame;
  logic [LIMIT_BITS-1:0] job_limit;
  logic [AREA_BITS-1:0]  job_det_area;

  logic [SCORE_BITS-1:0] score;
  logic                  match;
  logic                  full;
  logic                  done_next;
  logic [ID_BITS-1:0]    id_next;
  logic [SLOT_BITS-1:0]  slot_next;
  logic                  created_next;
  logic                  full_next;

  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_frames <= STEP_RESET;
    end else if (cfg_write && (paddr[PADDR_BITS-1:2] == REG_STEP_FRAMES)) begin
      step_frames <= pwdata[STEP_BITS-1:0];
    end
  end

  assign prdata = (paddr[PADDR_BITS-1:2] == REG_STEP_FRAMES) ? 32'(step_frames) : '0;

  // Request context, captured on acceptance.
  assign det_in = '{x: COORD_BITS'(box_x), y: COORD_BITS'(box_y),
                    w: COORD_BITS'(box_w), h: COORD_BITS'(box_h)};
  assign step_eff    = (step_frames == '0) ? STEP_BITS'(1) : step_frames;
  assign det_area_in = det_in.w * det_in.h;

  always_ff @(posedge clk) begin
    if (accept) begin
      job_det      <= det_in;
      job_frame    <= frame_index;
      job_limit    <= LIMIT_BITS'(step_eff) * LIMIT_BITS'(IDLE_STEPS);
      job_det_area <= det_area_in;
    end
  end

  assign job = '{clear: accept, det: job_det, frame: job_frame, limit: job_limit,
                 det_area: job_det_area};

  // Table storage and the shared compare unit.
  igt_track_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (scan_idx),
    .wr      (wr),
    .rd      (rd)
  );

  igt_iou_unit u_iou (
    .clk  (clk),
    .rst  (rst),
    .rd   (rd),
    .job  (job),
    .best (best),
    .idle (unit_idle)
  );

  // Match when inter >= union / 5, i.e. 5 * inter >= union.
  assign score = SCORE_BITS'(best.inter) * SCORE_BITS'(MATCH_DEN);
  assign match = best.found && (score >= SCORE_BITS'(best.uni));
  assign full  = (track_count == COUNT_BITS'(TRACK_SLOTS));

  // Sequencer: scan filled slots, drain the pipeline, decide and write back.
  always_comb begin
    state_next         = state;
    rd_en              = 1'b0;
    wr                 = '0;
    track_count_next   = track_count;
    next_identity_next = next_identity;
    done_next          = 1'b0;
    id_next            = '0;
    slot_next          = '0;
    created_next       = 1'b0;
    full_next          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (track_count == '0) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        if ((COUNT_BITS'(scan_idx) + COUNT_BITS'(1)) == track_count) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (unit_idle) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = ST_IDLE;
        done_next  = 1'b1;
        wr.box     = job_det;
        wr.frame   = job_frame;
        priority if (match) begin
          wr.en     = 1'b1;
          wr.addr   = best.slot;
          id_next   = best.ident;
          slot_next = best.slot;
        end else if (full) begin
          full_next = 1'b1;
        end else begin
          wr.en              = 1'b1;
          wr.ident_en        = 1'b1;
          wr.addr            = SLOT_BITS'(track_count);
          wr.ident           = next_identity;
          id_next            = next_identity;
          slot_next          = SLOT_BITS'(track_count);
          created_next       = 1'b1;
          next_identity_next = next_identity + ID_BITS'(1);
          track_count_next   = track_count + COUNT_BITS'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      scan_idx      <= '0;
      track_count   <= '0;
      next_identity <= '0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      track_count   <= track_count_next;
      next_identity <= next_identity_next;
      done          <= done_next;
      if (accept) begin
        scan_idx <= '0;
      end else if (rd_en) begin
        scan_idx <= scan_idx + SLOT_BITS'(1);
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (done_next) begin
      track_id   <= id_next;
      slot_index <= SLOT_OUT_BITS'(slot_next);
      created    <= created_next;
      table_full <= full_next;
    end
  end

  // A result only follows the decision cycle.
  a_done_after_decide: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_DECIDE))
    else $error("result strobe without a decision cycle");

  // A dropped detection reports no track.
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (done && table_full) |-> (!created && (track_id == '0) && (slot_index == '0)))
    else $error("dropped detection carries a track");

  // The table never grows past its size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    track_count <= COUNT_BITS'(TRACK_SLOTS))
    else $error("track count beyond table size");

  // An accepted request makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not start");

endmodule

`default_nettype wire

>>> tb/sv/tb_iou_greedy_track_association.sv
module tb_iou_greedy_track_association;
  timeunit 1ns;
  timeprecision 1ps;

  import igt_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 48;
  localparam int PHASES         = 7;
  localparam int PHASE_REQUESTS = 157;

  // One detection request as presented to the block.
  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    igt_box_t              box;
  } detection_t;

  // One association result.
  typedef struct packed {
    logic [ID_BITS-1:0]       id;
    logic [SLOT_OUT_BITS-1:0] slot;
    logic                     created;
    logic                     full;
  } assoc_t;

  // Shadow track table: predicts the association of every accepted request
  // and checks each result against the oldest prediction.
  class track_assoc_checker;
    logic [STEP_BITS-1:0]  step_frames;
    int unsigned           n_tracks;
    logic [ID_BITS-1:0]    next_ident;
    logic [ID_BITS-1:0]    ident [TRACK_SLOTS];
    igt_box_t              box [TRACK_SLOTS];
    logic [FRAME_BITS-1:0] last_frame [TRACK_SLOTS];
    assoc_t                pending_assocs [$];
    int unsigned           errors;
    int unsigned           n_created;
    int unsigned           n_updated;
    int unsigned           n_dropped;

    function new();
      step_frames = STEP_RESET;
      n_tracks    = 0;
      next_ident  = '0;
      errors      = 0;
      n_created   = 0;
      n_updated   = 0;
      n_dropped   = 0;
    endfunction

    function void set_step(logic [STEP_BITS-1:0] value);
      step_frames = value;
    endfunction

    // Length of the overlap of two spans; sums are taken at full width.
    function longint unsigned span_overlap(int unsigned p, int unsigned pl,
                                           int unsigned q, int unsigned ql);
      int unsigned lo;
      int unsigned hi;
      lo = (p > q) ? p : q;
      hi = (p + pl < q + ql) ? p + pl : q + ql;
      return (hi > lo) ? 64'(hi - lo) : 64'd0;
    endfunction

    // Greedy association of one detection with the current table.
    function assoc_t associate_detection(detection_t d);
      longint          age;
      longint          limit;
      longint unsigned inter;
      longint unsigned uni;
      longint unsigned best_i;
      longint unsigned best_u;
      bit              found;
      int unsigned     best;
      assoc_t          r;
      limit  = (step_frames == 0) ? IDLE_STEPS : longint'(64'(step_frames)) * IDLE_STEPS;
      found  = 1'b0;
      best   = 0;
      best_i = 0;
      best_u = 1;
      r      = '0;
      for (int s = 0; s < n_tracks; s++) begin
        // A signed age, so a track from a later frame is never skipped.
        age = $signed({32'd0, d.frame}) - $signed({32'd0, last_frame[s]});
        if (age > limit) continue;
        inter = span_overlap(box[s].x, box[s].w, d.box.x, d.box.w) *
                span_overlap(box[s].y, box[s].h, d.box.y, d.box.h);
        uni   = 64'(box[s].w) * 64'(box[s].h) + 64'(d.box.w) * 64'(d.box.h) - inter;
        if (inter == 0 || uni == 0) continue;
        // Exact fraction compare; equal scores keep the lower slot.
        if (inter * best_u > best_i * uni) begin
          best_i = inter;
          best_u = uni;
          best   = s;
          found  = 1'b1;
        end
      end
      if (found && best_i * MATCH_DEN >= best_u) begin
        box[best]        = d.box;
        last_frame[best] = d.frame;
        r.id             = ident[best];
        r.slot           = SLOT_OUT_BITS'(best);
        n_updated++;
      end else if (n_tracks >= TRACK_SLOTS) begin
        // No match and no room: the detection is dropped.
        r.full = 1'b1;
        n_dropped++;
      end else begin
        ident[n_tracks]      = next_ident;
        box[n_tracks]        = d.box;
        last_frame[n_tracks] = d.frame;
        r.id                 = next_ident;
        r.slot               = SLOT_OUT_BITS'(n_tracks);
        r.created            = 1'b1;
        next_ident           = next_ident + 1'b1;
        n_tracks++;
        n_created++;
      end
      return r;
    endfunction

    function void note_detection(detection_t d);
      pending_assocs.insert(pending_assocs.size(), associate_detection(d));
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_assoc(assoc_t got);
      assoc_t want;
      if (pending_assocs.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding, actual id %0d slot %0d",
                 $time, got.id, got.slot);
        return;
      end
      want = pending_assocs.pop_front();
      compare_field("track_id", 32'(want.id), 32'(got.id));
      compare_field("slot_index", 32'(want.slot), 32'(got.slot));
      compare_field("created", 32'(want.created), 32'(got.created));
      compare_field("table_full", 32'(want.full), 32'(got.full));
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [PADDR_BITS-1:0]       paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        start;
  logic [FRAME_BITS-1:0]       frame_index;
  logic [FIELD_COORD_BITS-1:0] box_x;
  logic [FIELD_COORD_BITS-1:0] box_y;
  logic [FIELD_COORD_BITS-1:0] box_w;
  logic [FIELD_COORD_BITS-1:0] box_h;
  logic                        busy;
  logic                        done;
  logic [ID_BITS-1:0]          track_id;
  logic [SLOT_OUT_BITS-1:0]    slot_index;
  logic                        created;
  logic                        table_full;

  track_assoc_checker    assoc_chk = new();
  logic [FRAME_BITS-1:0] cur_frame;
  int unsigned           n_sent = 0;
  int unsigned           quiet_cycles = 0;

  iou_greedy_track_association dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Results cannot be held off, so each one is taken on its strobe.
  always @(posedge clk) begin : result_monitor
    assoc_t seen;
    if (!rst && done) begin
      seen.id      = track_id;
      seen.slot    = slot_index;
      seen.created = created;
      seen.full    = table_full;
      assoc_chk.check_assoc(seen);
    end
  end

  // Stop the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL iou_greedy_track_association");
      $finish;
    end
  end

  // Present one request and wait until the block takes it. Start is left
  // high so that a following request can go out on the next cycle.
  task automatic send_detection(input detection_t d);
    start       <= 1'b1;
    frame_index <= d.frame;
    box_x       <= d.box.x;
    box_y       <= d.box.y;
    box_w       <= d.box.w;
    box_h       <= d.box.h;
    do @(posedge clk); while (busy);
    assoc_chk.note_detection(d);
    n_sent++;
  endtask

  task automatic send_box(input logic [31:0] frame, input int unsigned x, input int unsigned y,
                          input int unsigned w, input int unsigned h);
    detection_t d;
    d.frame = frame;
    d.box.x = FIELD_COORD_BITS'(x);
    d.box.y = FIELD_COORD_BITS'(y);
    d.box.w = FIELD_COORD_BITS'(w);
    d.box.h = FIELD_COORD_BITS'(h);
    send_detection(d);
  endtask

  task automatic hold_off(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Wait for every outstanding result, then let the block settle.
  task automatic drain_results(input int unsigned settle);
    start <= 1'b0;
    while (assoc_chk.pending_assocs.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_step(input logic [STEP_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_STEP_FRAMES, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    assoc_chk.set_step(value);
  endtask

  function automatic int jitter(input int unsigned span);
    int unsigned reach;
    reach = (span >> $urandom_range(0, 3)) + 1;
    return int'($urandom_range(0, 2 * reach)) - int'(reach);
  endfunction

  // Mostly detections that follow a known track, with new objects, empty
  // boxes and fully random requests mixed in.
  function automatic detection_t random_detection();
    detection_t  d;
    igt_box_t    base;
    int unsigned window;
    int unsigned pick;
    int unsigned slot;
    window = ((assoc_chk.step_frames == 0) ? 1 : assoc_chk.step_frames) * IDLE_STEPS;
    pick   = $urandom_range(0, 99);
    if (pick < 5) begin
      cur_frame += window + $urandom_range(1, 64);
    end else if (pick < 9) begin
      cur_frame -= $urandom_range(1, 64);
    end else begin
      cur_frame += $urandom_range(0, 2);
    end
    d.frame = cur_frame;
    pick    = $urandom_range(0, 99);
    if (pick < 60 && assoc_chk.n_tracks > 0) begin
      // Follow a track, sometimes close to its idle limit.
      slot    = $urandom_range(0, assoc_chk.n_tracks - 1);
      base    = assoc_chk.box[slot];
      d.frame = assoc_chk.last_frame[slot] + $urandom_range(0, window + window / 4 + 1);
      d.box.x = FIELD_COORD_BITS'(int'(base.x) + jitter(base.w));
      d.box.y = FIELD_COORD_BITS'(int'(base.y) + jitter(base.h));
      d.box.w = FIELD_COORD_BITS'(int'(base.w) + jitter(base.w));
      d.box.h = FIELD_COORD_BITS'(int'(base.h) + jitter(base.h));
    end else if (pick < 85) begin
      d.box.x = FIELD_COORD_BITS'($urandom_range(0, 4095));
      d.box.y = FIELD_COORD_BITS'($urandom_range(0, 4095));
      d.box.w = FIELD_COORD_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                               : $urandom_range(1, 300));
      d.box.h = FIELD_COORD_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                               : $urandom_range(1, 300));
      // Some new objects are empty boxes.
      if (pick >= 75) begin
        if ($urandom_range(0, 1) == 0) d.box.w = '0;
        else d.box.h = '0;
      end
    end else begin
      d.frame = $urandom;
      d.box   = igt_box_t'({$urandom, $urandom});
    end
    return d;
  endfunction

  initial begin : stimulus
    logic [STEP_BITS-1:0] steps [PHASES];
    bit                   idling;
    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    start       <= 1'b0;
    frame_index <= '0;
    box_x       <= '0;
    box_y       <= '0;
    box_w       <= '0;
    box_h       <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests with the reset frame step.
    send_box(32'd0, 0, 0, 10, 10);
    send_box(32'd0, 20, 0, 10, 10);
    // Equal scores of exactly one fifth: the lower slot takes it.
    send_box(32'd1, 5, 0, 20, 10);
    // Empty boxes never match, not even each other.
    send_box(32'd2, 0, 0, 0, 0);
    send_box(32'd2, 0, 0, 0, 0);
    send_box(32'd3, 4095, 4095, 4095, 4095);
    send_box(32'd3, 4095, 4095, 4095, 4095);
    // Track gone idle beyond five steps, then the frame going backwards.
    send_box(32'd36, 4095, 4095, 4095, 4095);
    send_box(32'd33, 4095, 4095, 4095, 4095);
    send_box(32'hFFFF_FFFF, 0, 0, 10, 10);
    send_box(32'd0, 0, 0, 4095, 4095);
    send_box(32'd40, 100, 200, 50, 60);
    send_box(32'd41, 110, 205, 50, 60);
    send_box(32'd41, 2730, 1365, 2730, 1365);
    send_box(32'd42, 1365, 2730, 1365, 2730);
    send_box(32'd45, 120, 210, 49, 61);
    drain_results(SETTLE_CYCLES);

    // Random phases, each under its own frame step.
    steps = '{14'd1, 14'd10000, 14'd0, 14'h3FFF, STEP_BITS'($urandom_range(2, 9999)),
              STEP_RESET, STEP_BITS'($urandom_range(2, 9999))};
    cur_frame = $urandom;
    for (int ph = 0; ph < PHASES; ph++) begin
      write_step(steps[ph]);
      idling = 1'b1;
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        send_detection(random_detection());
        if (i % 32 == 31) idling = $urandom_range(0, 1);
        if (ph == PHASES - 1) begin
          // No idling in the closing stretch.
        end else if ($urandom_range(0, 99) == 0) begin
          drain_results(0);
        end else if (idling && $urandom_range(0, 2) == 0) begin
          hold_off($urandom_range(1, 14));
        end
      end
      drain_results(SETTLE_CYCLES);
    end

    drain_results(END_CYCLES);
    $display("Ran %0d detections over the reset step and %0d written steps (0, 1, 10000, max).",
             n_sent, PHASES);
    $display("Tracks created %0d, updated %0d, dropped on a full table %0d.",
             assoc_chk.n_created, assoc_chk.n_updated, assoc_chk.n_dropped);
    if (assoc_chk.errors == 0 && assoc_chk.pending_assocs.size() == 0) begin
      $display("PASS iou_greedy_track_association");
    end else begin
      $display("FAIL iou_greedy_track_association");
    end
    $finish;
  end

endmodule
